### rtl/cbws_pkg.sv
// shared widths, reset values and sequencer states of the box window sum block
`timescale 1ns / 1ps

package cbws_pkg;

	localparam int PIXEL_W  = 8;
	localparam int SUM_W    = 14;
	localparam int RADIUS_W = 5;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_FLUSH,
		ST_SHORT
	} cbws_state_t;

endpackage

### rtl/cbws_in_if.sv
// pixel channel: one pixel and its end-of-line mark per item
`timescale 1ns / 1ps

interface cbws_in_if;
	logic                         valid;
	logic                         ready;
	logic [cbws_pkg::PIXEL_W-1:0] pixel;
	logic                         line_end;

	modport source (output valid, output pixel, output line_end, input ready);
	modport sink (input valid, input pixel, input line_end, output ready);
endinterface

### rtl/cbws_out_if.sv
// sum channel: one window sum and its final mark per item
`timescale 1ns / 1ps

interface cbws_out_if;
	logic                       valid;
	logic                       ready;
	logic [cbws_pkg::SUM_W-1:0] window_sum;
	logic                       final_sum;

	modport source (output valid, output window_sum, output final_sum, input ready);
	modport sink (input valid, input window_sum, input final_sum, output ready);
endinterface

### rtl/cbws_ring.sv
// pixel ring memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module cbws_ring #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [cbws_pkg::PIXEL_W-1:0]   wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [cbws_pkg::PIXEL_W-1:0]   rdata
);
	import cbws_pkg::*;

	logic [PIXEL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/cbws_seq.sv
// sequencer: running sum update, end-of-line flush and output register
`timescale 1ns / 1ps

module cbws_seq #(
	parameter int RING_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [cbws_pkg::RADIUS_W-1:0]      radius,
	cbws_in_if.sink                            pixels,
	cbws_out_if.source                         sums,
	output logic                               ring_we,
	output logic [$clog2(RING_DEPTH)-1:0]      ring_waddr,
	output logic [cbws_pkg::PIXEL_W-1:0]       ring_wdata,
	output logic                               ring_re,
	output logic [$clog2(RING_DEPTH)-1:0]      ring_raddr,
	input  logic [cbws_pkg::PIXEL_W-1:0]       ring_rdata
);
	import cbws_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int K_W   = RADIUS_W + 1;
	localparam int CMP_W = (CNT_W > K_W + 1) ? CNT_W : K_W + 1;
	localparam int AW    = (PTR_W + 1 > K_W + 1) ? PTR_W + 1 : K_W + 1;

	cbws_state_t state_q, state_d;

	logic [PTR_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    seen_q;
	logic [SUM_W-1:0]    total_q;
	logic [K_W-1:0]      k_q;
	logic [RADIUS_W-1:0] cnt_q;
	logic                out_valid_q;
	logic [SUM_W-1:0]    out_sum_q;
	logic                out_final_q;

	logic [PIXEL_W-1:0]  pix_s1;
	logic                last_s1;
	logic [CNT_W-1:0]    n_s1;
	logic [RADIUS_W-1:0] r_s1;

	logic               accept;
	logic               out_free;
	logic               load;
	logic [SUM_W-1:0]   load_sum;
	logic               load_final;
	logic               line_done;
	logic [PTR_W-1:0]   ptr_next;
	logic [CMP_W-1:0]   n_c;
	logic               sub_upd;
	logic               emit_upd;
	logic               flush_go;
	logic               final_upd;
	logic               short_go;
	logic [SUM_W-1:0]   total_upd;
	logic [SUM_W-1:0]   total_flush;
	logic               flush_last;
	logic               short_last;

	// ring slot that lies back entries before the one just before p
	function automatic logic [PTR_W-1:0] back_addr(input logic [PTR_W-1:0] p,
			input logic [K_W-1:0] back);
		logic [AW-1:0] d;
		d = AW'(p) + AW'(RING_DEPTH - 1) - AW'(back);
		if (d >= AW'(RING_DEPTH)) begin
			d = d - AW'(RING_DEPTH);
		end
		return PTR_W'(d);
	endfunction

	assign out_free = !out_valid_q || sums.ready;
	assign accept   = pixels.valid && pixels.ready;
	assign ptr_next = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);

	assign n_c       = CMP_W'(n_s1);
	assign sub_upd   = n_c >= CMP_W'({r_s1, 1'b0}) + CMP_W'(1);
	assign emit_upd  = n_c >= CMP_W'(r_s1);
	assign flush_go  = last_s1 && emit_upd && (r_s1 != '0);
	assign final_upd = last_s1 && emit_upd && (r_s1 == '0);
	assign short_go  = last_s1 && !emit_upd;
	assign total_upd = total_q + SUM_W'(pix_s1) - (sub_upd ? SUM_W'(ring_rdata) : '0);

	// positions past the last pixel drop the pixel k back, if the line has it
	assign total_flush = total_q - ((CMP_W'(k_q) <= n_c) ? SUM_W'(ring_rdata) : '0);
	assign flush_last  = k_q == K_W'(r_s1) + K_W'(1);
	assign short_last  = cnt_q == '0;

	assign ring_waddr = ptr_q;
	assign ring_wdata = pixels.pixel;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (flush_go) begin
					state_d = ST_FLUSH;
				end else if (short_go) begin
					state_d = ST_SHORT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free && flush_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SHORT: begin
				if (out_free && short_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pixels.ready = 1'b0;
		ring_we      = 1'b0;
		ring_re      = 1'b0;
		ring_raddr   = back_addr(ptr_q, {radius, 1'b0});
		load         = 1'b0;
		load_sum     = total_q;
		load_final   = 1'b0;
		line_done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pixels.ready = out_free;
				// read the pixel that leaves the window while the new one is stored
				ring_we      = pixels.valid && out_free;
				ring_re      = pixels.valid && out_free;
			end
			ST_UPDATE: begin
				load       = emit_upd;
				load_sum   = total_upd;
				load_final = final_upd;
				line_done  = final_upd;
				if (flush_go) begin
					ring_re    = 1'b1;
					ring_raddr = back_addr(ptr_q, {r_s1, 1'b0});
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					load       = 1'b1;
					load_sum   = total_flush;
					load_final = flush_last;
					line_done  = flush_last;
					if (!flush_last) begin
						ring_re    = 1'b1;
						ring_raddr = back_addr(ptr_q, k_q - K_W'(1));
					end
				end
			end
			ST_SHORT: begin
				if (out_free) begin
					load       = 1'b1;
					load_final = short_last;
					line_done  = short_last;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			seen_q      <= '0;
			total_q     <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ptr_q <= ptr_next;
				if (seen_q != CNT_W'(RING_DEPTH)) begin
					seen_q <= seen_q + CNT_W'(1);
				end
			end
			case (state_q)
				ST_UPDATE: begin
					total_q <= total_upd;
					k_q     <= {r_s1, 1'b0};
					cnt_q   <= RADIUS_W'(n_s1);
				end
				ST_FLUSH: begin
					if (out_free) begin
						total_q <= total_flush;
						k_q     <= k_q - K_W'(1);
					end
				end
				ST_SHORT: begin
					if (out_free) begin
						cnt_q <= cnt_q - RADIUS_W'(1);
					end
				end
				default: begin
					total_q <= total_q;
				end
			endcase
			// line over: next line starts from an empty window
			if (line_done) begin
				total_q <= '0;
				seen_q  <= '0;
				ptr_q   <= '0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (sums.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixels.pixel;
			last_s1 <= pixels.line_end;
			n_s1    <= seen_q;
			r_s1    <= radius;
		end
		if (load) begin
			out_sum_q   <= load_sum;
			out_final_q <= load_final;
		end
	end

	assign sums.valid      = out_valid_q;
	assign sums.window_sum = out_sum_q;
	assign sums.final_sum  = out_final_q;

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		line_done |=> (seen_q == '0 && ptr_q == '0 && total_q == '0))
		else $error("line state not cleared after final sum");

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(RING_DEPTH))
		else $error("pixel count past ring depth");

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_we && ring_re) |-> (ring_raddr != ring_waddr))
		else $error("ring read and write hit the same slot");

	a_flush_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (CMP_W'(k_q) > CMP_W'(r_s1)))
		else $error("flush step count ran below radius");

	a_short_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHORT) |-> (cnt_q < r_s1))
		else $error("short line repeat count out of range");

endmodule

### rtl/clipped_box_window_sum_core.sv
// top level: radius register and clamp, pixel ring and sequencer
//
// channel   direction  handshake      payload
// pixels    sink       valid/ready    pixel[7:0], line_end
// sums      source     valid/ready    window_sum[13:0], final_sum
// cfg       write      cfg_we         cfg_wdata[4:0] = window radius
//
// for each pixel the accept cycle writes the ring and reads the pixel that
// leaves the window; the running total is updated in the cycle after, and no
// pixel is accepted meanwhile; a line end adds r flush steps (one per remaining
// sum, one ring read each), or n+1 repeat steps for a line of n+1 <= r pixels
// the output register holds a sum until taken; no pixel is accepted while it
// is full and not being taken, and flush steps wait on it the same way
// reset clears the control state; the ring needs no clearing pass
`timescale 1ns / 1ps

module clipped_box_window_sum_core #(
	parameter int MAX_RADIUS = 31,
	parameter int RING_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cbws_pkg::RADIUS_W-1:0] cfg_wdata,
	cbws_in_if.sink                       pixels,
	cbws_out_if.source                    sums
);
	import cbws_pkg::*;

	localparam int PTR_W   = $clog2(RING_DEPTH);
	localparam int HALF_RD = (RING_DEPTH - 2) / 2;
	localparam int R_LIM   = (MAX_RADIUS < HALF_RD) ? MAX_RADIUS : HALF_RD;

	logic [RADIUS_W-1:0] radius_q;
	logic [RADIUS_W-1:0] radius_eff;

	logic               ring_we;
	logic [PTR_W-1:0]   ring_waddr;
	logic [PIXEL_W-1:0] ring_wdata;
	logic               ring_re;
	logic [PTR_W-1:0]   ring_raddr;
	logic [PIXEL_W-1:0] ring_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// the ring has to hold the whole window plus the pixel that leaves it
	assign radius_eff = (int'(radius_q) > R_LIM) ? RADIUS_W'(R_LIM) : radius_q;

	cbws_ring #(
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	cbws_seq #(
		.RING_DEPTH(RING_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.radius     (radius_eff),
		.pixels     (pixels),
		.sums       (sums),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_re    (ring_re),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata)
	);

endmodule

### verif/clipped_box_window_sum_core_test.sv
// self-checking testbench of the clipped box window sum core: directed table then random lines
`timescale 1ns / 1ps

module clipped_box_window_sum_core_test;

	localparam int RING_SLOTS  = 64;
	localparam int RADIUS_CAP  = 31;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE      = 8;
	localparam int TAIL_CYCLES = 40;
	localparam int ITEM_TARGET = 400;

	typedef struct {
		logic [cbws_pkg::SUM_W-1:0] window_sum;
		logic                       final_sum;
	} box_sum_t;

	typedef enum {ROW_RADIUS, ROW_PIXEL} row_kind_t;

	typedef struct {
		row_kind_t                    kind;
		logic [cbws_pkg::PIXEL_W-1:0] value;
		logic                         eol;
		bit                           typed;
		logic [cbws_pkg::SUM_W-1:0]   typed_sum;
		logic                         typed_final;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [cbws_pkg::RADIUS_W-1:0] cfg_wdata;

	cbws_in_if  pixels_if ();
	cbws_out_if sums_if ();

	clipped_box_window_sum_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixels    (pixels_if),
		.sums      (sums_if)
	);

	// predictor state
	logic [cbws_pkg::PIXEL_W-1:0]  line_ring [RING_SLOTS];
	logic [5:0]                    ring_wr;
	logic [cbws_pkg::SUM_W-1:0]    box_total;
	int                            line_count;
	logic [cbws_pkg::RADIUS_W-1:0] radius_reg;

	box_sum_t  expected_sums [$];
	stim_row_t directed_rows [$];

	bit                         quiet;
	bit                         cur_typed;
	logic [cbws_pkg::SUM_W-1:0] cur_typed_sum;
	logic                       cur_typed_final;

	int errors;
	int n_items;
	int n_sums;
	int n_finals;
	int n_radius_writes;
	int longest_line;
	int cur_line_len;
	int stall_cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [cbws_pkg::PIXEL_W-1:0] pixel_back(input int back);
		return line_ring[(int'(ring_wr) + RING_SLOTS - 1 - (back % RING_SLOTS)) % RING_SLOTS];
	endfunction

	// one pixel into the moving sum; queues the sums it releases when keep is set
	task automatic box_sum_step(input logic [cbws_pkg::PIXEL_W-1:0] pix, input logic eol,
			input bit keep);
		int r;
		int n;
		int k;
		box_sum_t res;
		box_sum_t outs [$];
		r = int'(radius_reg);
		if (r > RADIUS_CAP)
			r = RADIUS_CAP;
		if (r > (RING_SLOTS - 2) / 2)
			r = (RING_SLOTS - 2) / 2;
		n = line_count;
		res.final_sum = 1'b0;
		box_total = box_total + pix;
		if (n >= 2 * r + 1)
			box_total = box_total - pixel_back(2 * r);
		line_ring[ring_wr] = pix;
		ring_wr = ring_wr + 6'd1;
		if (line_count < RING_SLOTS)
			line_count++;
		if (n >= r) begin
			res.window_sum = box_total;
			outs.push_back(res);
		end
		if (eol) begin
			if (n >= r) begin
				// trailing positions lose one pixel each from the far left
				for (k = 2 * r; k > r; k--) begin
					if (k <= n)
						box_total = box_total - pixel_back(k);
					res.window_sum = box_total;
					outs.push_back(res);
				end
			end else begin
				// short line: every position sees the whole line
				for (k = 0; k <= n; k++) begin
					res.window_sum = box_total;
					outs.push_back(res);
				end
			end
			outs[outs.size() - 1].final_sum = 1'b1;
			box_total = '0;
			line_count = 0;
			ring_wr = '0;
		end
		if (keep)
			foreach (outs[i])
				expected_sums.push_back(outs[i]);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s got %0d want %0d at sum %0d", what, got, want, n_sums);
	endtask

	// output check, config tracking, prediction and watchdog, all on the sampling edge
	always @(posedge clk) begin
		box_sum_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (sums_if.valid && sums_if.ready) begin
				moved = 1'b1;
				n_sums++;
				if (sums_if.final_sum)
					n_finals++;
				if (expected_sums.size() == 0) begin
					report_mismatch("sum with nothing pending", sums_if.window_sum, 0);
				end else begin
					want = expected_sums.pop_front();
					if (sums_if.window_sum !== want.window_sum)
						report_mismatch("window_sum", sums_if.window_sum, want.window_sum);
					if (sums_if.final_sum !== want.final_sum)
						report_mismatch("final_sum", sums_if.final_sum, want.final_sum);
				end
			end
			if (cfg_we) begin
				moved = 1'b1;
				radius_reg = cfg_wdata;
				n_radius_writes++;
			end
			if (pixels_if.valid && pixels_if.ready) begin
				moved = 1'b1;
				n_items++;
				if (cur_typed) begin
					box_sum_step(pixels_if.pixel, pixels_if.line_end, 1'b0);
					want.window_sum = cur_typed_sum;
					want.final_sum = cur_typed_final;
					expected_sums.push_back(want);
				end else begin
					box_sum_step(pixels_if.pixel, pixels_if.line_end, 1'b1);
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles, %0d sums pending",
					STALL_LIMIT, expected_sums.size());
				$display("** clipped_box_window_sum_core: FAILED **");
				$finish;
			end
		end
	end

	always @(negedge clk)
		sums_if.ready <= quiet || ($urandom_range(99) >= 9);

	task automatic send_pixel(input logic [cbws_pkg::PIXEL_W-1:0] pix, input logic eol,
			input bit typed, input logic [cbws_pkg::SUM_W-1:0] tsum, input logic tfinal);
		while (!quiet && $urandom_range(99) < 9) begin
			pixels_if.valid <= 1'b0;
			@(negedge clk);
		end
		pixels_if.valid <= 1'b1;
		pixels_if.pixel <= pix;
		pixels_if.line_end <= eol;
		cur_typed = typed;
		cur_typed_sum = tsum;
		cur_typed_final = tfinal;
		do
			@(posedge clk);
		while (!pixels_if.ready);
		@(negedge clk);
		cur_line_len = eol ? 0 : cur_line_len + 1;
		if (cur_line_len + 1 > longest_line)
			longest_line = cur_line_len + 1;
	endtask

	// radius only changes with the block drained and settled
	task automatic set_radius(input logic [cbws_pkg::RADIUS_W-1:0] r);
		pixels_if.valid <= 1'b0;
		while (expected_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_row(input row_kind_t kind, input logic [cbws_pkg::PIXEL_W-1:0] value,
			input logic eol, input bit typed, input logic [cbws_pkg::SUM_W-1:0] tsum,
			input logic tfinal);
		stim_row_t row;
		row.kind = kind;
		row.value = value;
		row.eol = eol;
		row.typed = typed;
		row.typed_sum = tsum;
		row.typed_final = tfinal;
		directed_rows.push_back(row);
	endtask

	initial begin
		int sel;
		int len;
		int p;
		logic [cbws_pkg::PIXEL_W-1:0] pix;
		logic [cbws_pkg::RADIUS_W-1:0] r;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pixels_if.valid = 1'b0;
		pixels_if.pixel = '0;
		pixels_if.line_end = 1'b0;
		sums_if.ready = 1'b0;
		quiet = 1'b0;
		cur_typed = 1'b0;
		cur_typed_sum = '0;
		cur_typed_final = 1'b0;
		errors = 0;
		n_items = 0;
		n_sums = 0;
		n_finals = 0;
		n_radius_writes = 0;
		longest_line = 0;
		cur_line_len = 0;
		stall_cycles = 0;
		foreach (line_ring[i])
			line_ring[i] = '0;
		ring_wr = '0;
		box_total = '0;
		line_count = 0;
		radius_reg = cbws_pkg::RADIUS_RESET;

		// reset radius, single-pixel lines at both pixel extremes
		add_row(ROW_PIXEL, 8'd255, 1'b1, 1'b1, 14'd255, 1'b1);
		add_row(ROW_PIXEL, 8'd0,   1'b1, 1'b1, 14'd0,   1'b1);
		// zero radius: each sum is its own pixel
		add_row(ROW_RADIUS, 8'd0, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd255, 1'b0, 1'b1, 14'd255, 1'b0);
		add_row(ROW_PIXEL, 8'd0,   1'b1, 1'b1, 14'd0,   1'b1);
		// largest radius with a short line
		add_row(ROW_RADIUS, 8'd31, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd255, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd255, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd255, 1'b1, 1'b0, '0, 1'b0);
		// clipping at both line ends
		add_row(ROW_RADIUS, 8'd2, 1'b0, 1'b0, '0, 1'b0);
		for (int i = 1; i <= 6; i++)
			add_row(ROW_PIXEL, 8'(i), i == 6, 1'b0, '0, 1'b0);
		// line no longer than the radius, then one pixel longer
		add_row(ROW_PIXEL, 8'd10, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd20, 1'b1, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd7, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd8, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd9, 1'b1, 1'b0, '0, 1'b0);
		// radius grows in the middle of a line
		add_row(ROW_PIXEL, 8'd10, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd20, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd30, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_RADIUS, 8'd3, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd40, 1'b0, 1'b0, '0, 1'b0);
		add_row(ROW_PIXEL, 8'd50, 1'b1, 1'b0, '0, 1'b0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_RADIUS)
				set_radius(directed_rows[i].value[cbws_pkg::RADIUS_W-1:0]);
			else
				send_pixel(directed_rows[i].value, directed_rows[i].eol, directed_rows[i].typed,
					directed_rows[i].typed_sum, directed_rows[i].typed_final);
		end

		// random lines, mostly short, some long enough to wrap the ring
		while (n_items < ITEM_TARGET) begin
			if ($urandom_range(2) == 0) begin
				sel = $urandom_range(9);
				r = (sel == 0) ? 5'd0 : (sel == 1) ? 5'd31 : 5'($urandom_range(31));
				set_radius(r);
			end
			sel = $urandom_range(99);
			if (sel < 10)
				len = $urandom_range(3, 1);
			else if (sel < 85)
				len = $urandom_range(24, 1);
			else if (sel < 95)
				len = $urandom_range(70, 25);
			else
				len = $urandom_range(90, 64);
			for (p = 0; p < len; p++) begin
				quiet = (n_items >= 150) && (n_items < 250);
				sel = $urandom_range(9);
				pix = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(255));
				send_pixel(pix, p == len - 1, 1'b0, '0, 1'b0);
				if (p != len - 1 && $urandom_range(39) == 0)
					set_radius(5'($urandom_range(31)));
			end
		end
		quiet = 1'b0;
		pixels_if.valid <= 1'b0;

		while (expected_sums.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_sums.size() != 0)
			report_mismatch("sums never delivered", 0, expected_sums.size());

		$display("run: %0d pixels, %0d sums over %0d lines, longest line %0d pixels",
			n_items, n_sums, n_finals, longest_line);
		$display("run: %0d radius writes including 0 and 31, %0d mismatches",
			n_radius_writes, errors);
		if (errors == 0) begin
			$display("** clipped_box_window_sum_core: PASSED **");
		end else begin
			$display("** clipped_box_window_sum_core: FAILED **");
		end
		$finish;
	end

endmodule

### clipped_box_window_sum_core.f
rtl/cbws_pkg.sv
rtl/cbws_in_if.sv
rtl/cbws_out_if.sv
rtl/cbws_ring.sv
rtl/cbws_seq.sv
rtl/clipped_box_window_sum_core.sv
verif/clipped_box_window_sum_core_test.sv
